// File: design/irpd_pkg.sv
package irpd_pkg;

  // Field widths of the item and result payloads
  localparam int unsigned LenW  = 6;
  localparam int unsigned WordW = 32;
  localparam int unsigned CfgW  = 8;
  localparam int unsigned CfgIdxW = 2;

  // Longest frame that is sent; longer lengths saturate here
  localparam logic [LenW-1:0] MaxFrameBits = LenW'(32);

  // Register reset values
  localparam logic [CfgW-1:0] BlockTicksRst        = 8'd40;
  localparam logic [CfgW-1:0] PulseTicksRst        = 8'd20;
  localparam logic [CfgW-1:0] LeaderOnBlocksRst    = 8'd8;
  localparam logic [CfgW-1:0] LeaderTotalBlocksRst = 8'd12;

  // Block counter saturates at this value
  localparam logic [CfgW-1:0] BlockCountMax = 8'hFF;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_TICKS         = 2'd0,
    CFG_PULSE_TICKS         = 2'd1,
    CFG_LEADER_ON_BLOCKS    = 2'd2,
    CFG_LEADER_TOTAL_BLOCKS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] block_ticks;
    logic [CfgW-1:0] pulse_ticks;
    logic [CfgW-1:0] leader_on_blocks;
    logic [CfgW-1:0] leader_total_blocks;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic [LenW-1:0]   frame_bits;
    logic [WordW-1:0]  frame_data;
  } item_t;

  typedef struct packed {
    logic carrier_on;
    logic busy_res;
    logic frame_waiting;
  } res_t;

endpackage

// File: design/irpd_in_if.sv
interface irpd_in_if;
  import irpd_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [LenW-1:0]  frame_bits;
  logic [WordW-1:0] frame_data;

  modport source (output valid, command, frame_bits, frame_data, input ready);
  modport sink   (input valid, command, frame_bits, frame_data, output ready);
endinterface

// File: design/irpd_out_if.sv
interface irpd_out_if;
  logic valid;
  logic ready;
  logic carrier_on;
  logic busy_res;
  logic frame_waiting;

  modport source (output valid, carrier_on, busy_res, frame_waiting, input ready);
  modport sink   (input valid, carrier_on, busy_res, frame_waiting, output ready);
endinterface

// File: design/ir_pulse_distance_transmitter.sv
// Pipeline: an accepted item passes the input register, then the result register,
//   which drives out_o.valid; one result per input item.
// Throughput: one item per cycle unless out_o.ready holds the result register;
//   the frame state updates in a single pass.
// Reset (rst_ni, async low): frame state and both stage valids clear,
//   registers return to 40/20/8/12 ticks and blocks.
module ir_pulse_distance_transmitter
  import irpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  irpd_in_if.sink            in_i,
  irpd_out_if.source         out_o
);

  cfg_t  cfg;
  item_t item_q;
  logic  in_valid_q;
  res_t  res_q, res;
  logic  out_valid_q;
  logic  out_free;
  logic  step;

  irpd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Stage handshake
  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.command    <= in_i.command;
      item_q.frame_bits <= in_i.frame_bits;
      item_q.frame_data <= in_i.frame_data;
    end
  end

  irpd_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.carrier_on    = res_q.carrier_on;
  assign out_o.busy_res      = res_q.busy_res;
  assign out_o.frame_waiting = res_q.frame_waiting;

endmodule

// File: design/irpd_cfg.sv
module irpd_cfg
  import irpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Register file write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BLOCK_TICKS:         cfg_d.block_ticks         = cfg_data_i;
        CFG_PULSE_TICKS:         cfg_d.pulse_ticks         = cfg_data_i;
        CFG_LEADER_ON_BLOCKS:    cfg_d.leader_on_blocks    = cfg_data_i;
        CFG_LEADER_TOTAL_BLOCKS: cfg_d.leader_total_blocks = cfg_data_i;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_ticks         <= BlockTicksRst;
      cfg_q.pulse_ticks         <= PulseTicksRst;
      cfg_q.leader_on_blocks    <= LeaderOnBlocksRst;
      cfg_q.leader_total_blocks <= LeaderTotalBlocksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/irpd_engine.sv
module irpd_engine
  import irpd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  logic             pending_valid_q, pending_valid_d;
  logic [LenW-1:0]  pending_length_q, pending_length_d;
  logic [WordW-1:0] pending_word_q, pending_word_d;
  logic             sending_q, sending_d;
  logic [LenW-1:0]  active_length_q, active_length_d;
  logic [WordW-1:0] active_word_q, active_word_d;
  logic [CfgW-1:0]  tick_count_q, tick_count_d;
  logic [CfgW-1:0]  block_count_q, block_count_d;
  logic [LenW-1:0]  pulses_sent_q, pulses_sent_d;
  logic             one_gap_q, one_gap_d;
  logic             gate_level_q, gate_level_d;

  logic [CfgW-1:0]  next_tick;
  logic             live;

  // Next-state logic for one transfer
  always_comb begin
    pending_valid_d  = pending_valid_q;
    pending_length_d = pending_length_q;
    pending_word_d   = pending_word_q;
    sending_d        = sending_q;
    active_length_d  = active_length_q;
    active_word_d    = active_word_q;
    tick_count_d     = tick_count_q;
    block_count_d    = block_count_q;
    pulses_sent_d    = pulses_sent_q;
    one_gap_d        = one_gap_q;
    gate_level_d     = gate_level_q;
    next_tick        = '0;
    live             = 1'b0;

    if (step_i) begin
      if (item_i.command == CMD_LOAD) begin
        // store pending frame, length saturated
        pending_length_d = (item_i.frame_bits > MaxFrameBits) ? MaxFrameBits
                                                             : item_i.frame_bits;
        pending_word_d   = item_i.frame_data;
        pending_valid_d  = 1'b1;
      end else begin
        // idle block picks up the pending frame
        if (!sending_q && pending_valid_q) begin
          active_length_d = pending_length_q;
          active_word_d   = pending_word_q;
          pending_valid_d = 1'b0;
          sending_d       = 1'b1;
          tick_count_d    = '0;
          block_count_d   = '0;
          pulses_sent_d   = '0;
          one_gap_d       = 1'b0;
        end
        live = sending_d;

        if (live) begin
          // gate decision
          if (block_count_d < cfg_i.leader_on_blocks) begin
            gate_level_d = 1'b1;
          end else if (block_count_d < cfg_i.leader_total_blocks) begin
            gate_level_d = 1'b0;
          end else if (pulses_sent_d <= active_length_d && tick_count_d == '0) begin
            if (pulses_sent_d == '0) begin
              gate_level_d  = 1'b1;
              pulses_sent_d = pulses_sent_d + LenW'(1);
            end else if (one_gap_d || !active_word_d[WordW-1]) begin
              gate_level_d  = 1'b1;
              one_gap_d     = 1'b0;
              active_word_d = {active_word_d[WordW-2:0], 1'b0};
              pulses_sent_d = pulses_sent_d + LenW'(1);
            end else begin
              gate_level_d = 1'b0;
              one_gap_d    = 1'b1;
            end
          end else if (tick_count_d == cfg_i.pulse_ticks) begin
            gate_level_d = 1'b0;
          end else if (tick_count_d == '0) begin
            gate_level_d = 1'b0;
            sending_d    = 1'b0;
          end

          // tick and saturating block counters
          next_tick = tick_count_d + CfgW'(1);
          if (next_tick >= cfg_i.block_ticks) begin
            tick_count_d = '0;
            if (block_count_d != BlockCountMax) begin
              block_count_d = block_count_d + CfgW'(1);
            end
          end else begin
            tick_count_d = next_tick;
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_valid_q  <= 1'b0;
      pending_length_q <= '0;
      pending_word_q   <= '0;
      sending_q        <= 1'b0;
      active_length_q  <= '0;
      active_word_q    <= '0;
      tick_count_q     <= '0;
      block_count_q    <= '0;
      pulses_sent_q    <= '0;
      one_gap_q        <= 1'b0;
      gate_level_q     <= 1'b0;
    end else begin
      pending_valid_q  <= pending_valid_d;
      pending_length_q <= pending_length_d;
      pending_word_q   <= pending_word_d;
      sending_q        <= sending_d;
      active_length_q  <= active_length_d;
      active_word_q    <= active_word_d;
      tick_count_q     <= tick_count_d;
      block_count_q    <= block_count_d;
      pulses_sent_q    <= pulses_sent_d;
      one_gap_q        <= one_gap_d;
      gate_level_q     <= gate_level_d;
    end
  end

  // Result seen after the update
  assign res_o.carrier_on    = gate_level_d;
  assign res_o.busy_res      = sending_d;
  assign res_o.frame_waiting = pending_valid_d;

`ifndef ASSERT_OFF
  a_load_sets_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.command == CMD_LOAD |=> pending_valid_q)
    else $error("load did not leave a pending frame");

  a_gate_only_sending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gate_level_q |-> sending_q)
    else $error("carrier gated on while not sending");

  a_pulse_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sending_q |-> ({1'b0, pulses_sent_q} <= {1'b0, active_length_q} + 7'd1))
    else $error("more pulses than frame length allows");

  a_hold_without_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(tick_count_q) && $stable(block_count_q) && $stable(sending_q))
    else $error("state moved without a transfer");
`endif

endmodule

// File: tb/tb_ir_pulse_distance_transmitter.sv
`timescale 1ns / 1ps

module tb_ir_pulse_distance_transmitter;
  import irpd_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldOffCycles = 150;

  // Mirror of the transmitter gate: tracks frame state, queues expected outputs
  class ir_frame_scoreboard;
    cfg_t             regs;
    bit               pend_valid;
    logic [LenW-1:0]  pend_len;
    logic [WordW-1:0] pend_word;
    bit               sending;
    logic [LenW-1:0]  act_len;
    logic [WordW-1:0] act_word;
    logic [CfgW-1:0]  tick_cnt;
    logic [CfgW-1:0]  block_cnt;
    logic [LenW-1:0]  pulses;
    bit               one_gap;
    bit               gate;
    res_t             gate_q[$];
    int unsigned      n_errors;
    int unsigned      n_checked;
    int unsigned      n_loads;
    int unsigned      n_ticks;
    int unsigned      n_frames;

    function new();
      regs = '{block_ticks: BlockTicksRst, pulse_ticks: PulseTicksRst,
               leader_on_blocks: LeaderOnBlocksRst,
               leader_total_blocks: LeaderTotalBlocksRst};
      pend_valid = 1'b0;
      pend_len   = '0;
      pend_word  = '0;
      sending    = 1'b0;
      act_len    = '0;
      act_word   = '0;
      tick_cnt   = '0;
      block_cnt  = '0;
      pulses     = '0;
      one_gap    = 1'b0;
      gate       = 1'b0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
      case (idx)
        CFG_BLOCK_TICKS:         regs.block_ticks = val;
        CFG_PULSE_TICKS:         regs.pulse_ticks = val;
        CFG_LEADER_ON_BLOCKS:    regs.leader_on_blocks = val;
        CFG_LEADER_TOTAL_BLOCKS: regs.leader_total_blocks = val;
        default: ;
      endcase
    endfunction

    function bit frame_active();
      return sending || pend_valid;
    endfunction

    function int unsigned outstanding();
      return gate_q.size();
    endfunction

    // One carrier tick: start a pending frame if idle, then decide the gate
    function void carrier_tick();
      logic [CfgW-1:0] nxt;
      if (!sending && pend_valid) begin
        act_len    = pend_len;
        act_word   = pend_word;
        pend_valid = 1'b0;
        sending    = 1'b1;
        tick_cnt   = '0;
        block_cnt  = '0;
        pulses     = '0;
        one_gap    = 1'b0;
        n_frames++;
      end
      if (!sending) return;

      if (block_cnt < regs.leader_on_blocks) begin
        gate = 1'b1;
      end else if (block_cnt < regs.leader_total_blocks) begin
        gate = 1'b0;
      end else if (pulses <= act_len && tick_cnt == '0) begin
        if (pulses == '0) begin
          // start pulse
          gate = 1'b1;
          pulses++;
        end else if (one_gap || !act_word[WordW-1]) begin
          gate     = 1'b1;
          one_gap  = 1'b0;
          act_word = act_word << 1;
          pulses++;
        end else begin
          // a one bit: one silent block first
          gate    = 1'b0;
          one_gap = 1'b1;
        end
      end else if (tick_cnt == regs.pulse_ticks) begin
        gate = 1'b0;
      end else if (tick_cnt == '0) begin
        gate    = 1'b0;
        sending = 1'b0;
      end

      // tick and block counters; block count saturates
      nxt = tick_cnt + CfgW'(1);
      if (nxt >= regs.block_ticks) begin
        tick_cnt = '0;
        if (block_cnt != BlockCountMax) block_cnt++;
      end else begin
        tick_cnt = nxt;
      end
    endfunction

    function void note_item(item_t it);
      if (it.command == CMD_LOAD) begin
        pend_len   = (it.frame_bits > MaxFrameBits) ? MaxFrameBits : it.frame_bits;
        pend_word  = it.frame_data;
        pend_valid = 1'b1;
        n_loads++;
      end else begin
        carrier_tick();
        n_ticks++;
      end
      gate_q.push_back(res_t'{carrier_on: gate, busy_res: sending,
                              frame_waiting: pend_valid});
    endfunction

    task report(string what);
      n_errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(res_t got);
      res_t exp;
      if (gate_q.size() == 0) begin
        report($sformatf("unexpected output transfer %b", got));
        return;
      end
      exp = gate_q.pop_front();
      n_checked++;
      if (got.carrier_on !== exp.carrier_on)
        report($sformatf("result %0d carrier_on %b, want %b", n_checked,
                         got.carrier_on, exp.carrier_on));
      if (got.busy_res !== exp.busy_res)
        report($sformatf("result %0d busy_res %b, want %b", n_checked,
                         got.busy_res, exp.busy_res));
      if (got.frame_waiting !== exp.frame_waiting)
        report($sformatf("result %0d frame_waiting %b, want %b", n_checked,
                         got.frame_waiting, exp.frame_waiting));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  irpd_in_if  in_if ();
  irpd_out_if out_if ();

  ir_frame_scoreboard sb;

  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned hold_req;
  int unsigned stall_left;
  int unsigned phase_items;
  int unsigned n_settings;
  int unsigned cycles;

  ir_pulse_distance_transmitter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: check each transfer, then choose ready for the next edge
  always @(posedge clk_i) begin
    res_t got;
    if (out_if.valid && out_if.ready) begin
      got = '{carrier_on: out_if.carrier_on, busy_res: out_if.busy_res,
              frame_waiting: out_if.frame_waiting};
      sb.check_result(got);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (hold_req > 0) begin
      // long hold-off so the block backs up into its input
      stall_left = hold_req - 1;
      hold_req   = 0;
      out_if.ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Offer one item and hold it until the transfer
  task automatic put_item(cmd_e cmd, logic [LenW-1:0] bits, logic [WordW-1:0] data);
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.frame_bits <= bits;
    in_if.frame_data <= data;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(item_t'{command: cmd, frame_bits: bits, frame_data: data});
    phase_items++;
    if (tx_idle_on && $urandom_range(0, 9) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic wait_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // Registers change only once the block has gone quiet
  task automatic apply_settings(cfg_t c);
    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(CFG_BLOCK_TICKS, c.block_ticks);
    write_reg(CFG_PULSE_TICKS, c.pulse_ticks);
    write_reg(CFG_LEADER_ON_BLOCKS, c.leader_on_blocks);
    write_reg(CFG_LEADER_TOTAL_BLOCKS, c.leader_total_blocks);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Load a frame, then tick until it is out; noise adds stray loads and cut-offs
  task automatic send_frame(int unsigned max_bits, bit noisy);
    logic [LenW-1:0] bits;
    int unsigned     guard;
    case ($urandom_range(0, 15))
      0:       bits = (max_bits >= 4) ? LenW'($urandom_range(33, 63)) : '0;
      1:       bits = '0;
      default: bits = LenW'($urandom_range(0, max_bits));
    endcase
    put_item(CMD_LOAD, bits, $urandom());
    guard = 0;
    while (sb.frame_active() && guard < 2000) begin
      guard++;
      if (noisy && $urandom_range(0, 39) == 0) begin
        put_item(CMD_LOAD, LenW'($urandom_range(0, max_bits + 2)), $urandom());
      end else if (noisy && $urandom_range(0, 59) == 0) begin
        break;
      end else begin
        // payload of a tick is ignored but still toggled
        put_item(CMD_TICK, LenW'($urandom_range(0, 63)), $urandom());
      end
    end
    repeat ($urandom_range(0, 3)) put_item(CMD_TICK, LenW'($urandom_range(0, 63)), $urandom());
  endtask

  task automatic run_phase(cfg_t c, int unsigned quota, int unsigned max_bits,
                           bit noisy, bit idle);
    apply_settings(c);
    tx_idle_on  = idle;
    rx_idle_on  = idle;
    phase_items = 0;
    while (phase_items < quota) send_frame(max_bits, noisy);
  endtask

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.block_ticks         = CfgW'($urandom_range(1, 4));
    c.pulse_ticks         = CfgW'($urandom_range(1, 5));
    c.leader_on_blocks    = CfgW'($urandom_range(0, 4));
    c.leader_total_blocks = CfgW'($urandom_range(0, 6));
    return c;
  endfunction

  initial begin
    sb               = new();
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_BLOCK_TICKS;
    cfg_data_i       = '0;
    in_if.valid      = 1'b0;
    in_if.command    = CMD_TICK;
    in_if.frame_bits = '0;
    in_if.frame_data = '0;
    out_if.ready     = 1'b0;
    tx_idle_on       = 1'b1;
    rx_idle_on       = 1'b1;
    hold_req         = 0;
    stall_left       = 0;
    cycles           = 0;
    n_settings       = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, idle tick, oversize and empty loads, replacement
    put_item(CMD_TICK, '1, '1);
    put_item(CMD_LOAD, 6'd63, 32'hFFFF_FFFF);
    put_item(CMD_LOAD, 6'd0, 32'h0000_0000);
    put_item(CMD_TICK, '0, '0);
    put_item(CMD_LOAD, 6'd32, 32'h8000_0001);
    repeat (5) put_item(CMD_TICK, '0, '0);
    put_item(CMD_LOAD, 6'd33, 32'hAAAA_5555);
    put_item(CMD_LOAD, 6'd1, 32'h0000_0000);
    repeat (4) put_item(CMD_TICK, 6'h15, 32'h5555_AAAA);

    // Shortest blocks, no leader, pulse never ends inside a block
    run_phase('{block_ticks: 8'd1, pulse_ticks: 8'd1, leader_on_blocks: 8'd0,
                leader_total_blocks: 8'd0}, 50, 6, 1'b1, 1'b1);
    // Zero block length: every tick closes a block
    run_phase('{block_ticks: 8'd0, pulse_ticks: 8'd1, leader_on_blocks: 8'd1,
                leader_total_blocks: 8'd2}, 50, 6, 1'b1, 1'b1);

    // Back-pressure: receiver holds off while items keep coming, then a full drain
    apply_settings('{block_ticks: 8'd4, pulse_ticks: 8'd2, leader_on_blocks: 8'd2,
                     leader_total_blocks: 8'd3});
    phase_items = 0;
    hold_req = HoldOffCycles;
    send_frame(6, 1'b1);
    wait_results();
    while (phase_items < 70) send_frame(8, 1'b1);

    // Leader with no off part
    run_phase('{block_ticks: 8'd3, pulse_ticks: 8'd1, leader_on_blocks: 8'd5,
                leader_total_blocks: 8'd2}, 40, 6, 1'b1, 1'b1);
    // Block counter runs into saturation, widest pulse setting
    run_phase('{block_ticks: 8'd1, pulse_ticks: 8'd255, leader_on_blocks: 8'd255,
                leader_total_blocks: 8'd255}, 1, 3, 1'b0, 1'b1);
    // Longest block, pulse ends at the last tick of it
    run_phase('{block_ticks: 8'd255, pulse_ticks: 8'd254, leader_on_blocks: 8'd0,
                leader_total_blocks: 8'd0}, 1, 0, 1'b0, 1'b1);

    repeat (3) run_phase(rand_cfg(), 30, 8, 1'b1, 1'b1);
    // Closing stretch at full rate
    run_phase(rand_cfg(), 60, 8, 1'b1, 1'b0);

    wait_results();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Covered %0d loads and %0d carrier ticks, %0d frames started,",
             sb.n_loads, sb.n_ticks, sb.n_frames);
    $display("over %0d register settings; %0d results checked, %0d mismatches.",
             n_settings, sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
